>>> hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on the same edge
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following edge
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ecc_pkg.sv
package ecc_pkg;
  localparam int FIELD_BITS  = 16;
  localparam int SCALAR_BITS = 16;
  localparam int IDX_BITS    = $clog2(SCALAR_BITS);
  localparam int CNT_BITS    = $clog2(FIELD_BITS);
  localparam logic CFG_PRIME = 1'b0;
  localparam logic CFG_A     = 1'b1;
endpackage

>>> hw/rtl/ecc_point_scalar_multiply.sv
// channel | direction | handshake          | payload
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
// in      | in        | in_valid/in_stall   | scalar, point_x, point_y
// out     | out       | out_valid/out_stall | result_x, result_y, result_at_infinity
// One item at a time through a shared bit-serial modular multiplier.
// Each scalar bit runs a double and each set bit also an add, each with an
// exponentiation inverse of up to 2*FIELD_BITS products (the most when p-2 is
// nearly all ones); small p or sparse scalars take far fewer.
// in_stall is high from acceptance until the result beat is taken.
// Synchronous reset clears the sequencer and restores p=7, a=0.
module ecc_point_scalar_multiply (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_index,
  input  logic [ecc_pkg::FIELD_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ecc_pkg::SCALAR_BITS-1:0] scalar,
  input  logic [ecc_pkg::FIELD_BITS-1:0] point_x,
  input  logic [ecc_pkg::FIELD_BITS-1:0] point_y,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ecc_pkg::FIELD_BITS-1:0] result_x,
  output logic [ecc_pkg::FIELD_BITS-1:0] result_y,
  output logic                           result_at_infinity
);
  import ecc_pkg::*;

  localparam int W = FIELD_BITS;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_RX    = 4'd2;
  localparam logic [3:0] S_RY    = 4'd3;
  localparam logic [3:0] S_RA    = 4'd4;
  localparam logic [3:0] S_ADD   = 4'd5;
  localparam logic [3:0] S_T1    = 4'd6;
  localparam logic [3:0] S_IINIT = 4'd7;
  localparam logic [3:0] S_ISTEP = 4'd8;
  localparam logic [3:0] S_IR    = 4'd9;
  localparam logic [3:0] S_IB    = 4'd10;
  localparam logic [3:0] S_LAM   = 4'd11;
  localparam logic [3:0] S_X3    = 4'd12;
  localparam logic [3:0] S_Y3    = 4'd13;
  localparam logic [3:0] S_NEXT  = 4'd14;
  localparam logic [3:0] S_DONE  = 4'd15;

  logic [W-1:0] field_prime, curve_a;
  logic [3:0]   state, ret;

  logic [SCALAR_BITS-1:0] d;
  logic [W-1:0] raw_y;
  logic [W-1:0] bx, by, av;
  logic         b_inf;
  logic [W-1:0] acc_x, acc_y;
  logic         acc_inf;
  logic [IDX_BITS-1:0] idx;
  logic         add_phase;
  logic [W-1:0] num, den, ir, ib, e, lam, x3;

  // shared multiplier: r = (2r + bit*u) mod p, MSB of v first
  logic [W-1:0]    mu, mv, mr;
  logic [CNT_BITS-1:0] mcnt;
  logic [W+1:0]    m_sum, m_s1, m_s2, p_ext;

  function automatic logic [W-1:0] addm(input logic [W-1:0] u, v, p);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, p}) s = s - {1'b0, p};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] u, v, p);
    logic [W:0] s;
    if (u >= v) s = {1'b0, u} - {1'b0, v};
    else s = {1'b0, u} + {1'b0, p} - {1'b0, v};
    return s[W-1:0];
  endfunction

  always_comb begin
    p_ext = {2'b00, field_prime};
    m_sum = {1'b0, mr, 1'b0} + (mv[W-1] ? {2'b00, mu} : '0);
    m_s1  = (m_sum >= p_ext) ? m_sum - p_ext : m_sum;
    m_s2  = (m_s1 >= p_ext) ? m_s1 - p_ext : m_s1;
  end

  logic [W-1:0] ox, oy, t3, x3n, dx;
  logic         o_inf;
  always_comb begin
    ox    = add_phase ? bx : acc_x;
    oy    = add_phase ? by : acc_y;
    o_inf = add_phase ? b_inf : acc_inf;
    t3    = addm(addm(addm(mr, mr, field_prime), mr, field_prime), av, field_prime);
    x3n   = subm(subm(mr, acc_x, field_prime), ox, field_prime);
    dx    = subm(acc_x, x3n, field_prime);
  end

  assign cfg_ready          = 1'b1;
  assign in_stall           = (state != S_IDLE);
  assign out_valid          = (state == S_DONE);
  assign result_x           = acc_x;
  assign result_y           = acc_y;
  assign result_at_infinity = acc_inf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      field_prime <= W'(7);
      curve_a     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_PRIME: field_prime <= cfg_data;
          CFG_A:     curve_a     <= cfg_data;
          default:   ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            d       <= scalar;
            raw_y   <= point_y;
            acc_x   <= '0;
            acc_y   <= '0;
            acc_inf <= 1'b1;
            if (field_prime < W'(2)) begin
              state <= S_DONE;
            end else begin
              mu <= W'(1); mv <= point_x; mr <= '0; mcnt <= '0;
              ret <= S_RX; state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          mr   <= m_s2[W-1:0];
          mv   <= {mv[W-2:0], 1'b0};
          mcnt <= mcnt + 1'b1;
          if (mcnt == CNT_BITS'(W-1)) state <= ret;
        end
        S_RX: begin
          bx <= mr;
          mu <= W'(1); mv <= raw_y; mr <= '0; mcnt <= '0;
          ret <= S_RY; state <= S_MUL;
        end
        S_RY: begin
          by <= mr;
          mu <= W'(1); mv <= curve_a; mr <= '0; mcnt <= '0;
          ret <= S_RA; state <= S_MUL;
        end
        S_RA: begin
          av        <= mr;
          b_inf     <= (bx == '0) && (by == '0);
          idx       <= IDX_BITS'(SCALAR_BITS-1);
          add_phase <= 1'b0;
          state     <= S_ADD;
        end
        S_ADD: begin
          if (acc_inf) begin
            acc_x <= ox; acc_y <= oy; acc_inf <= o_inf;
            state <= S_NEXT;
          end else if (o_inf) begin
            state <= S_NEXT;
          end else if (acc_x == ox) begin
            if (acc_y != oy || acc_y == '0) begin
              acc_x <= '0; acc_y <= '0; acc_inf <= 1'b1;
              state <= S_NEXT;
            end else begin
              den <= addm(acc_y, acc_y, field_prime);
              mu <= acc_x; mv <= acc_x; mr <= '0; mcnt <= '0;
              ret <= S_T1; state <= S_MUL;
            end
          end else begin
            num   <= subm(oy, acc_y, field_prime);
            den   <= subm(ox, acc_x, field_prime);
            state <= S_IINIT;
          end
        end
        S_T1: begin
          num   <= t3;
          state <= S_IINIT;
        end
        S_IINIT: begin
          ir    <= W'(1);
          ib    <= den;
          e     <= field_prime - W'(2);
          state <= S_ISTEP;
        end
        S_ISTEP: begin
          mr <= '0; mcnt <= '0;
          if (e == '0) begin
            mu <= num; mv <= ir; ret <= S_LAM;
          end else if (e[0]) begin
            mu <= ir; mv <= ib; ret <= S_IR;
          end else begin
            mu <= ib; mv <= ib; ret <= S_IB;
          end
          state <= S_MUL;
        end
        S_IR: begin
          ir <= mr;
          mu <= ib; mv <= ib; mr <= '0; mcnt <= '0;
          ret <= S_IB; state <= S_MUL;
        end
        S_IB: begin
          ib    <= mr;
          e     <= e >> 1;
          state <= S_ISTEP;
        end
        S_LAM: begin
          lam <= mr;
          mu <= mr; mv <= mr; mr <= '0; mcnt <= '0;
          ret <= S_X3; state <= S_MUL;
        end
        S_X3: begin
          x3 <= x3n;
          mu <= lam; mv <= dx; mr <= '0; mcnt <= '0;
          ret <= S_Y3; state <= S_MUL;
        end
        S_Y3: begin
          acc_x   <= x3;
          acc_y   <= subm(mr, acc_y, field_prime);
          acc_inf <= 1'b0;
          state   <= S_NEXT;
        end
        S_NEXT: begin
          if (!add_phase && d[idx]) begin
            add_phase <= 1'b1;
            state     <= S_ADD;
          end else if (idx == '0) begin
            state <= S_DONE;
          end else begin
            idx       <= idx - 1'b1;
            add_phase <= 1'b0;
            state     <= S_ADD;
          end
        end
        S_DONE: begin
          if (!out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hw/rtl/ecc_chk.sv
`include "assert_macros.svh"
module ecc_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [ecc_pkg::FIELD_BITS-1:0]  result_x,
  input logic [ecc_pkg::FIELD_BITS-1:0]  result_y,
  input logic                            result_at_infinity
);
  `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result beat dropped")
  `ASSERT_SAME(a_inf_zero, out_valid && result_at_infinity, ~|{result_x, result_y}, "inf not 0")
  `ASSERT_SAME(a_busy_out, out_valid, in_stall, "input open while result pending")
  `ASSERT_NEXT(a_busy_acc, in_valid && !in_stall, in_stall, "input open after accept")
endmodule

bind ecc_point_scalar_multiply ecc_chk u_ecc_chk (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ecc_pkg::*;

  localparam longint unsigned CYCLE_LIMIT = 40_000_000;
  localparam int HOLD_CYCLES = 40000;

  typedef struct {
    longint unsigned x;
    longint unsigned y;
    bit              inf;
  } ec_point_t;

  typedef struct {
    logic [FIELD_BITS-1:0] x;
    logic [FIELD_BITS-1:0] y;
    logic                  inf;
  } mult_result_t;

  class mult_scoreboard;
    mult_result_t    pending_q[$];
    int              errors = 0;
    longint unsigned prime = 7;
    longint unsigned coef_a = 0;

    function longint unsigned fmul(longint unsigned u, longint unsigned v,
                                   longint unsigned p);
      return (u * v) % p;
    endfunction

    function longint unsigned fsub(longint unsigned u, longint unsigned v,
                                   longint unsigned p);
      return (u >= v) ? (u - v) : (u + p - v);
    endfunction

    // inverse by Fermat power u^(p-2)
    function longint unsigned finv(longint unsigned u, longint unsigned p);
      longint unsigned e, r, b;
      e = p - 2;
      r = 1 % p;
      b = u % p;
      while (e != 0) begin
        if (e[0]) r = fmul(r, b, p);
        b = fmul(b, b, p);
        e = e >> 1;
      end
      return r;
    endfunction

    function ec_point_t point_add(ec_point_t q, ec_point_t r, longint unsigned a,
                                  longint unsigned p);
      longint unsigned lam, x3;
      ec_point_t s;
      if (q.inf) return r;
      if (r.inf) return q;
      if (q.x == r.x) begin
        if (q.y != r.y || q.y == 0) begin
          s.x = 0; s.y = 0; s.inf = 1;
          return s;
        end
        lam = (fmul(3, fmul(q.x, q.x, p), p) + a) % p;
        lam = fmul(lam, finv((2 * q.y) % p, p), p);
      end else begin
        lam = fmul(fsub(r.y, q.y, p), finv(fsub(r.x, q.x, p), p), p);
      end
      x3 = fsub(fsub(fmul(lam, lam, p), q.x, p), r.x, p);
      s.y = fsub(fmul(lam, fsub(q.x, x3, p), p), q.y, p);
      s.x = x3;
      s.inf = 0;
      return s;
    endfunction

    function void note_input(logic [SCALAR_BITS-1:0] d, logic [FIELD_BITS-1:0] px,
                             logic [FIELD_BITS-1:0] py);
      ec_point_t acc, base;
      longint unsigned a;
      mult_result_t res;
      acc.x = 0; acc.y = 0; acc.inf = 1;
      if (prime >= 2) begin
        a = coef_a % prime;
        base.x = px % prime;
        base.y = py % prime;
        base.inf = (base.x == 0 && base.y == 0);
        for (int i = SCALAR_BITS - 1; i >= 0; i--) begin
          acc = point_add(acc, acc, a, prime);
          if (d[i]) acc = point_add(acc, base, a, prime);
        end
      end
      res.x = acc.inf ? '0 : acc.x[FIELD_BITS-1:0];
      res.y = acc.inf ? '0 : acc.y[FIELD_BITS-1:0];
      res.inf = acc.inf;
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [FIELD_BITS-1:0] rx, logic [FIELD_BITS-1:0] ry,
                               logic rinf);
      mult_result_t exp_r;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat x=%0d y=%0d inf=%0d", rx, ry, rinf);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (rx !== exp_r.x) begin
        $error("result_x expected %0d got %0d", exp_r.x, rx);
        errors++;
      end
      if (ry !== exp_r.y) begin
        $error("result_y expected %0d got %0d", exp_r.y, ry);
        errors++;
      end
      if (rinf !== exp_r.inf) begin
        $error("result_at_infinity expected %0d got %0d", exp_r.inf, rinf);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic cfg_index = CFG_PRIME;
  logic [FIELD_BITS-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [SCALAR_BITS-1:0] scalar = '0;
  logic [FIELD_BITS-1:0] point_x = '0;
  logic [FIELD_BITS-1:0] point_y = '0;
  logic out_valid;
  logic out_stall = 0;
  logic [FIELD_BITS-1:0] result_x;
  logic [FIELD_BITS-1:0] result_y;
  logic result_at_infinity;

  mult_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold = 0;
  int hold_cnt = 0;
  longint unsigned cycles = 0;

  ecc_point_scalar_multiply DUT (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // receiver: long hold-off counts up in its own process once requested
  always @(posedge clk) begin
    if (long_hold && hold_cnt < HOLD_CYCLES) begin
      hold_cnt  <= hold_cnt + 1;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(result_x, result_y, result_at_infinity);
  end

  task automatic write_reg(logic idx, logic [FIELD_BITS-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    if (idx == CFG_PRIME) sb.prime = val;
    else sb.coef_a = val;
  endtask

  task automatic send_mult(logic [SCALAR_BITS-1:0] d, logic [FIELD_BITS-1:0] px,
                           logic [FIELD_BITS-1:0] py);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1;
    scalar <= d;
    point_x <= px;
    point_y <= py;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(d, px, py);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_random();
    logic [FIELD_BITS-1:0] px, py;
    logic [SCALAR_BITS-1:0] d;
    int unsigned p;
    p = 32'(sb.prime);
    d = ($urandom_range(0, 7) == 0) ? SCALAR_BITS'($urandom_range(0, 3))
                                    : SCALAR_BITS'($urandom);
    if (p >= 2 && $urandom_range(0, 99) < 85) begin
      // any (x,y) lies on some curve with this a, since b is free
      px = FIELD_BITS'($urandom_range(0, p - 1));
      py = FIELD_BITS'($urandom_range(0, p - 1));
    end else begin
      px = FIELD_BITS'($urandom);
      py = FIELD_BITS'($urandom);
    end
    send_mult(d, px, py);
  endtask

  int unsigned primes[7] = '{65521, 3, 0, 1, 65535, 251, 7};
  int unsigned coefs[7] = '{65535, 0, 5, 0, 1234, 0, 3};

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    write_reg(CFG_PRIME, 16'd7);
    write_reg(CFG_A, 16'd0);
    // directed: zero and unit scalars, infinity input, y=0 doubling, reduction
    send_mult(16'd0, 16'd3, 16'd1);
    send_mult(16'd1, 16'd3, 16'd1);
    send_mult(16'd2, 16'd3, 16'd1);
    send_mult(16'hFFFF, 16'd3, 16'd1);
    send_mult(16'd5, 16'd0, 16'd0);
    send_mult(16'd5, 16'd7, 16'd14);
    send_mult(16'd2, 16'd4, 16'd0);
    send_mult(16'd3, 16'd4, 16'd0);
    send_mult(16'd1, 16'hFFFF, 16'hFFFF);
    send_mult(16'h8000, 16'd2, 16'd5);
    send_mult(16'd7, 16'd1, 16'd6);
    send_mult(16'hAAAA, 16'h5555, 16'hAAAA);
    drain();
    write_reg(CFG_PRIME, 16'd65521);
    write_reg(CFG_A, 16'd65535);
    send_mult(16'd1, 16'd65520, 16'd65520);
    send_mult(16'hFFFF, 16'd65520, 16'd1);
    send_mult(16'd2, 16'd12345, 16'd0);
    send_mult(16'd3, 16'd0, 16'd0);
    send_mult(16'h5555, 16'hFFFF, 16'h0000);
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      write_reg(CFG_PRIME, FIELD_BITS'(primes[ph]));
      write_reg(CFG_A, FIELD_BITS'(coefs[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      if (ph == 0) long_hold <= 1;
      for (int n = 0; n < 40; n++) begin
        if (ph == 1 && n == 20) drain();
        send_random();
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/ecc_pkg.sv
hw/rtl/ecc_point_scalar_multiply.sv
hw/rtl/ecc_chk.sv
tb/testbench.sv
